// ===== design/binary_grid_component_sizes_defines.svh =====
// assertion helpers shared by the checker
`ifndef BINARY_GRID_COMPONENT_SIZES_DEFINES_SVH
`define BINARY_GRID_COMPONENT_SIZES_DEFINES_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define BGCS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BGCS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/bgcs_pkg.sv =====
package bgcs_pkg;

    localparam int MAX_SIDE_DEF = 32;
    localparam int SIDE_W       = 6;
    localparam logic [SIDE_W-1:0] SIDE_RST = 6'd25;
    localparam int CMD_W        = 2;
    localparam int VALUE_W      = 11;
    localparam int STATUS_W     = 2;
    // widest cell address and size over the supported side range
    localparam int ADDR_MAX_W   = 12;
    localparam int SIZE_MAX_W   = 13;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BUSY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_END  = 2'd2;

    localparam logic [VALUE_W-1:0] VALUE_MAX = 11'd2047;

    typedef struct packed {
        logic                  en;
        logic [ADDR_MAX_W-1:0] addr;
        logic                  bits;
    } t_grid_wr;

    typedef struct packed {
        logic                  valid;
        logic [SIZE_MAX_W-1:0] size;
    } t_group;

    function automatic logic [VALUE_W-1:0] sat_value(input logic [31:0] v);
        logic [VALUE_W-1:0] r;
        if (v > 32'(VALUE_MAX)) begin
            r = VALUE_MAX;
        end else begin
            r = v[VALUE_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== design/bgcs_in_if.sv =====
interface bgcs_in_if;
    logic                         valid;
    logic                         ready;
    logic [bgcs_pkg::CMD_W-1:0]   command;
    logic                         pixel;
    modport source (output valid, output command, output pixel, input ready);
    modport sink   (input valid, input command, input pixel, output ready);
endinterface

// ===== design/bgcs_out_if.sv =====
interface bgcs_out_if;
    logic                            valid;
    logic                            ready;
    logic [bgcs_pkg::VALUE_W-1:0]    value;
    logic                            is_size;
    logic                            last_result;
    logic [bgcs_pkg::STATUS_W-1:0]   status;
    modport source (output valid, output value, output is_size, output last_result,
                    output status, input ready);
    modport sink   (input valid, input value, input is_size, input last_result,
                    input status, output ready);
endinterface

// ===== design/bgcs_cfg_if.sv =====
interface bgcs_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [bgcs_pkg::SIDE_W-1:0]   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/binary_grid_component_sizes.sv =====
// 4-connected group sizes of a square binary grid
// i_in   : command/pixel transfers; load pushes one cell in raster order,
//          read pulls the next result, clear starts a new grid
// o_out  : one result per read: group count first, then sizes in ascending
//          order, last_result on the final one; status busy while loading,
//          end once the list is exhausted
// i_cfg  : grid side; a write also clears the grid, taken only while idle
// loads are taken one per cycle unless a side write or a stalled result waits.
// the last pixel starts the labelling engine, during which i_in is held off:
// every cell is scanned; a filled cell adds a queue fetch and four neighbour
// probes on the one grid port; each group size is inserted, moving larger ones
// a read that moves the position waits for the sizes memory to fetch the next
// entry; the result is registered and sits in the cycle after the transfer
// a stalled receiver holds one result in the output register; the next
// input transfer waits until that register is free
// reset gives side 25, an empty size list and the loading phase
module binary_grid_component_sizes #(
    parameter int MAX_SIDE = bgcs_pkg::MAX_SIDE_DEF
) (
    input logic          i_clk,
    input logic          i_rst_n,
    bgcs_in_if.sink      i_in,
    bgcs_out_if.source   o_out,
    bgcs_cfg_if.sink     i_cfg
);
    localparam int RW  = $clog2(MAX_SIDE);
    localparam int SW  = $clog2(MAX_SIDE+1);
    localparam int AW  = 2 * RW;
    localparam int CW  = AW + 1;
    localparam int GIW = $clog2(MAX_SIDE * MAX_SIDE / 2 + 1);

    localparam logic [1:0] P_LOAD = 2'd0;
    localparam logic [1:0] P_FILL = 2'd1;
    localparam logic [1:0] P_DONE = 2'd2;

    logic [1:0]    r_ph, n_ph;
    logic [bgcs_pkg::SIDE_W-1:0] r_side;
    logic [RW-1:0] r_lr, n_lr, r_lc, n_lc;
    logic [CW-1:0] r_rpos, n_rpos;
    logic          r_stale;
    logic          r_ov;
    logic [bgcs_pkg::VALUE_W-1:0]  r_val, n_val;
    logic          r_isz, n_isz, r_last, n_last;
    logic [bgcs_pkg::STATUS_W-1:0] r_st, n_st;

    logic [SW-1:0] side;
    logic          in_xfer, cfg_xfer, load_last, start, fill_done, sort_busy;
    bgcs_pkg::t_grid_wr wr;
    bgcs_pkg::t_group   grp;
    logic [CW-1:0] count, sz_q;

    // zero reads as one, anything above the maximum as the maximum
    always_comb begin
        if (r_side == '0) begin
            side = SW'(1);
        end else if (32'(r_side) > 32'(MAX_SIDE)) begin
            side = SW'(MAX_SIDE);
        end else begin
            side = SW'(r_side);
        end
    end

    // a pending side write goes first, the input waits while it is pending
    assign i_in.ready  = (r_ph == P_LOAD || r_ph == P_DONE) && !r_stale
                         && (!r_ov || o_out.ready) && !i_cfg.valid;
    assign i_cfg.ready = r_ph == P_LOAD || r_ph == P_DONE;
    assign in_xfer  = i_in.valid && i_in.ready;
    assign cfg_xfer = i_cfg.valid && i_cfg.ready;

    assign load_last = (SW'(r_lr) == side - SW'(1)) && (SW'(r_lc) == side - SW'(1));
    assign wr.en   = in_xfer && !cfg_xfer && r_ph == P_LOAD && i_in.command == bgcs_pkg::CMD_LOAD;
    assign wr.addr = bgcs_pkg::ADDR_MAX_W'({r_lr, r_lc});
    assign wr.bits = i_in.pixel;
    assign start   = wr.en && load_last;

    bgcs_fill #(.MAX_SIDE(MAX_SIDE)) u_fill (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_wr(wr), .i_start(start), .i_side(side),
        .i_sort_busy(sort_busy), .o_grp(grp), .o_done(fill_done)
    );

    bgcs_sort #(.MAX_SIDE(MAX_SIDE)) u_sort (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_clr(start), .i_grp(grp),
        .i_rd_idx(GIW'(r_rpos - 1'b1)), .o_busy(sort_busy), .o_count(count),
        .o_rd_data(sz_q)
    );

    always_comb begin
        n_ph = r_ph;
        n_lr = r_lr;
        n_lc = r_lc;
        n_rpos = r_rpos;
        n_val = '0;
        n_isz = 1'b0;
        n_last = 1'b0;
        n_st = bgcs_pkg::ST_OK;
        if (cfg_xfer) begin
            n_ph = P_LOAD;
            n_lr = '0;
            n_lc = '0;
            n_rpos = '0;
        end else if (in_xfer) begin
            unique case (i_in.command)
                bgcs_pkg::CMD_LOAD: begin
                    if (r_ph == P_LOAD) begin
                        if (load_last) begin
                            n_ph = P_FILL;
                        end else if (SW'(r_lc) == side - SW'(1)) begin
                            n_lc = '0;
                            n_lr = r_lr + 1'b1;
                        end else begin
                            n_lc = r_lc + 1'b1;
                        end
                    end
                end
                bgcs_pkg::CMD_READ: begin
                    if (r_ph != P_DONE) begin
                        n_st = bgcs_pkg::ST_BUSY;
                    end else if (r_rpos == '0) begin
                        n_val = bgcs_pkg::sat_value(32'(count));
                        n_last = count == '0;
                        n_rpos = CW'(1);
                    end else if (r_rpos <= count) begin
                        n_val = bgcs_pkg::sat_value(32'(sz_q));
                        n_isz = 1'b1;
                        n_last = r_rpos == count;
                        n_rpos = r_rpos + 1'b1;
                    end else begin
                        n_st = bgcs_pkg::ST_END;
                    end
                end
                bgcs_pkg::CMD_CLEAR: begin
                    n_ph = P_LOAD;
                    n_lr = '0;
                    n_lc = '0;
                    n_rpos = '0;
                end
                default: ;
            endcase
        end else if (r_ph == P_FILL && fill_done) begin
            n_ph = P_DONE;
            n_rpos = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= P_LOAD;
            r_side <= bgcs_pkg::SIDE_RST;
            r_lr <= '0;
            r_lc <= '0;
            r_rpos <= '0;
            r_stale <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_ph <= n_ph;
            r_lr <= n_lr;
            r_lc <= n_lc;
            r_rpos <= n_rpos;
            // the registered sizes memory read must follow a new read position first
            r_stale <= (n_rpos != r_rpos) || (n_ph != r_ph);
            if (cfg_xfer) begin
                r_side <= i_cfg.data;
            end
            if (in_xfer && !cfg_xfer && i_in.command == bgcs_pkg::CMD_READ) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
        if (in_xfer && !cfg_xfer && i_in.command == bgcs_pkg::CMD_READ) begin
            r_val <= n_val;
            r_isz <= n_isz;
            r_last <= n_last;
            r_st <= n_st;
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.value       = r_val;
    assign o_out.is_size     = r_isz;
    assign o_out.last_result = r_last;
    assign o_out.status      = r_st;
endmodule

// ===== design/bgcs_fill.sv =====
module bgcs_fill #(
    parameter int MAX_SIDE = bgcs_pkg::MAX_SIDE_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bgcs_pkg::t_grid_wr           i_wr,
    input  logic                         i_start,
    input  logic [$clog2(MAX_SIDE+1)-1:0] i_side,
    input  logic                         i_sort_busy,
    output bgcs_pkg::t_group             o_grp,
    output logic                         o_done
);
    localparam int RW = $clog2(MAX_SIDE);
    localparam int SW = $clog2(MAX_SIDE+1);
    localparam int AW = 2 * RW;
    localparam int CW = AW + 1;

    localparam logic [3:0] F_IDLE = 4'd0;
    localparam logic [3:0] F_SCAN = 4'd1;
    localparam logic [3:0] F_SCK  = 4'd2;
    localparam logic [3:0] F_QRD  = 4'd3;
    localparam logic [3:0] F_QGET = 4'd4;
    localparam logic [3:0] F_NRD  = 4'd5;
    localparam logic [3:0] F_NCK  = 4'd6;
    localparam logic [3:0] F_EMIT = 4'd7;
    localparam logic [3:0] F_WAIT = 4'd8;

    logic          m_grid [2**AW];
    logic [AW-1:0] m_queue [2**AW];

    logic [3:0]    r_state, n_state;
    logic [RW-1:0] r_pr, n_pr, r_pc, n_pc, r_cr, n_cr, r_cc, n_cc;
    logic [1:0]    r_k, n_k;
    logic [AW:0]   r_head, n_head, r_tail, n_tail;
    logic [CW-1:0] r_size, n_size;
    logic [AW-1:0] r_naddr, n_naddr, r_qq;
    logic          r_nval, n_nval, r_gq;

    logic [RW-1:0] nb_r, nb_c;
    logic          nb_v;
    logic [AW-1:0] g_ra, g_wa, q_wa;
    logic          g_we, g_wd, q_we;
    logic [AW-1:0] q_wd;
    logic          scan_last, advance;

    // neighbour order: below, above, left, right
    always_comb begin
        nb_r = r_cr;
        nb_c = r_cc;
        nb_v = 1'b0;
        unique case (r_k)
            2'd0: begin
                nb_r = r_cr + 1'b1;
                nb_v = (SW'(r_cr) + SW'(1)) < i_side;
            end
            2'd1: begin
                nb_r = r_cr - 1'b1;
                nb_v = r_cr != '0;
            end
            2'd2: begin
                nb_c = r_cc - 1'b1;
                nb_v = r_cc != '0;
            end
            default: begin
                nb_c = r_cc + 1'b1;
                nb_v = (SW'(r_cc) + SW'(1)) < i_side;
            end
        endcase
    end

    assign scan_last = (SW'(r_pr) == i_side - SW'(1)) && (SW'(r_pc) == i_side - SW'(1));
    assign advance   = ((r_state == F_SCK) && !r_gq) || ((r_state == F_WAIT) && !i_sort_busy);
    assign o_done    = advance && scan_last;
    assign o_grp.valid = r_state == F_EMIT;
    assign o_grp.size  = bgcs_pkg::SIZE_MAX_W'(r_size);

    assign g_ra = (r_state == F_SCAN) ? {r_pr, r_pc} : {nb_r, nb_c};

    always_comb begin
        g_we = 1'b0;
        g_wa = {r_pr, r_pc};
        g_wd = 1'b0;
        q_we = 1'b0;
        q_wa = '0;
        q_wd = {r_pr, r_pc};
        if (i_wr.en) begin
            g_we = 1'b1;
            g_wa = i_wr.addr[AW-1:0];
            g_wd = i_wr.bits;
        end else if (r_state == F_SCK && r_gq) begin
            g_we = 1'b1;
            q_we = 1'b1;
        end else if (r_state == F_NCK && r_nval && r_gq) begin
            g_we = 1'b1;
            g_wa = r_naddr;
            q_we = 1'b1;
            q_wa = r_tail[AW-1:0];
            q_wd = r_naddr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (g_we) begin
            m_grid[g_wa] <= g_wd;
        end
        if (q_we) begin
            m_queue[q_wa] <= q_wd;
        end
        r_gq <= m_grid[g_ra];
        r_qq <= m_queue[r_head[AW-1:0]];
    end

    always_comb begin
        n_state = r_state;
        n_pr = r_pr;  n_pc = r_pc;
        n_cr = r_cr;  n_cc = r_cc;
        n_k = r_k;
        n_head = r_head;  n_tail = r_tail;
        n_size = r_size;
        n_naddr = r_naddr;  n_nval = r_nval;
        unique case (r_state)
            F_IDLE: begin
                if (i_start) begin
                    n_pr = '0;
                    n_pc = '0;
                    n_state = F_SCAN;
                end
            end
            F_SCAN: n_state = F_SCK;
            F_SCK: begin
                if (r_gq) begin
                    n_head = '0;
                    n_tail = (AW+1)'(1);
                    n_size = '0;
                    n_state = F_QRD;
                end
            end
            F_QRD: n_state = (r_head == r_tail) ? F_EMIT : F_QGET;
            F_QGET: begin
                n_cr = r_qq[AW-1:RW];
                n_cc = r_qq[RW-1:0];
                n_head = r_head + 1'b1;
                n_size = r_size + 1'b1;
                n_k = '0;
                n_state = F_NRD;
            end
            F_NRD: begin
                n_naddr = {nb_r, nb_c};
                n_nval = nb_v;
                n_state = F_NCK;
            end
            F_NCK: begin
                if (r_nval && r_gq) begin
                    n_tail = r_tail + 1'b1;
                end
                n_k = r_k + 1'b1;
                n_state = (r_k == 2'd3) ? F_QRD : F_NRD;
            end
            F_EMIT: n_state = F_WAIT;
            F_WAIT: ;
            default: n_state = F_IDLE;
        endcase
        if (advance) begin
            if (scan_last) begin
                n_state = F_IDLE;
            end else begin
                n_state = F_SCAN;
                if (SW'(r_pc) == i_side - SW'(1)) begin
                    n_pc = '0;
                    n_pr = r_pr + 1'b1;
                end else begin
                    n_pc = r_pc + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_pr <= n_pr;  r_pc <= n_pc;
        r_cr <= n_cr;  r_cc <= n_cc;
        r_k <= n_k;
        r_head <= n_head;  r_tail <= n_tail;
        r_size <= n_size;
        r_naddr <= n_naddr;  r_nval <= n_nval;
    end
endmodule

// ===== design/bgcs_sort.sv =====
module bgcs_sort #(
    parameter int MAX_SIDE = bgcs_pkg::MAX_SIDE_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_clr,
    input  bgcs_pkg::t_group       i_grp,
    input  logic [$clog2(MAX_SIDE*MAX_SIDE/2+1)-1:0] i_rd_idx,
    output logic                   o_busy,
    output logic [2*$clog2(MAX_SIDE):0] o_count,
    output logic [2*$clog2(MAX_SIDE):0] o_rd_data
);
    localparam int CW  = 2 * $clog2(MAX_SIDE) + 1;
    localparam int GD  = MAX_SIDE * MAX_SIDE / 2 + 1;
    localparam int GIW = $clog2(GD);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_CK   = 2'd2;

    logic [CW-1:0] m_sizes [GD];

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count, r_j, n_j, r_key, n_key, r_q;
    logic [GIW-1:0] ra, wa;
    logic          we;
    logic [CW-1:0] wd;

    assign o_busy    = r_state != S_IDLE;
    assign o_count   = r_count;
    assign o_rd_data = r_q;

    assign ra = (r_state == S_RD) ? GIW'(r_j - 1'b1) : i_rd_idx;

    // insertion: shift larger entries up one place until the key fits
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_j = r_j;
        n_key = r_key;
        we = 1'b0;
        wa = r_j[GIW-1:0];
        wd = r_key;
        unique case (r_state)
            S_IDLE: begin
                if (i_grp.valid) begin
                    n_key = CW'(i_grp.size);
                    n_j = r_count;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                if (r_j == '0) begin
                    we = 1'b1;
                    n_count = r_count + 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_CK;
                end
            end
            S_CK: begin
                we = 1'b1;
                if (r_q > r_key) begin
                    wd = r_q;
                    n_j = r_j - 1'b1;
                    n_state = S_RD;
                end else begin
                    n_count = r_count + 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (i_clr) begin
            n_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            m_sizes[wa] <= wd;
        end
        r_q <= m_sizes[ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_j <= n_j;
        r_key <= n_key;
    end
endmodule

// ===== design/bgcs_checker.sv =====
`include "binary_grid_component_sizes_defines.svh"

module bgcs_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            i_in_ready,
    input logic [bgcs_pkg::CMD_W-1:0]      i_in_command,
    input logic                            i_out_valid,
    input logic                            i_out_ready,
    input logic [bgcs_pkg::VALUE_W-1:0]    i_out_value,
    input logic                            i_out_is_size,
    input logic                            i_out_last,
    input logic [bgcs_pkg::STATUS_W-1:0]   i_out_status
);
    `BGCS_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_out_value) && $stable(i_out_status), "result changed while stalled")
    `BGCS_ASSERT_NEXT(a_read_result, i_in_valid && i_in_ready && i_in_command == bgcs_pkg::CMD_READ,
        i_out_valid, "read transfer gave no result")
    `BGCS_ASSERT_NOW(a_status_empty, i_out_valid && i_out_status != bgcs_pkg::ST_OK,
        i_out_value == '0 && !i_out_is_size && !i_out_last, "non-ok result carries data")
    `BGCS_ASSERT_NOW(a_status_code, i_out_valid,
        i_out_status == bgcs_pkg::ST_OK || i_out_status == bgcs_pkg::ST_BUSY
        || i_out_status == bgcs_pkg::ST_END, "bad status code")
endmodule

bind binary_grid_component_sizes bgcs_checker u_bgcs_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_in_valid(i_in.valid), .i_in_ready(i_in.ready), .i_in_command(i_in.command),
    .i_out_valid(o_out.valid), .i_out_ready(o_out.ready), .i_out_value(o_out.value),
    .i_out_is_size(o_out.is_size), .i_out_last(o_out.last_result),
    .i_out_status(o_out.status)
);
